[rtl/packed12_depth_unpacker_macros.svh]
// Assertion macros shared by the checker of the packed 12-bit depth unpacker.
`ifndef PACKED12_DEPTH_UNPACKER_MACROS_SVH
`define PACKED12_DEPTH_UNPACKER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define P12DU_ASSERT_IMPL(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define P12DU_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// Same-cycle implication that also holds across reset.
`define P12DU_ASSERT_ALWAYS(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) (a) |-> (b)) else $error(msg);

`endif

[rtl/p12du_pkg.sv]
// Types and constants of the packed 12-bit depth unpacker.
package p12du_pkg;

  localparam int ELEMENT_BYTES_DEF     = 24;
  localparam int CODES_PER_ELEMENT_DEF = 16;
  localparam int BYTE_W                = 8;
  localparam int CODE_W                = 12;
  localparam int DEPTH_W               = 16;
  localparam int TABLE_DEPTH           = 4096;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  typedef struct packed {
    logic                op;
    logic [BYTE_W-1:0]   data_byte;
    logic                frame_begin;
    logic [CODE_W-1:0]   table_index;
    logic [DEPTH_W-1:0]  table_value;
  } item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                valid;
    result_t             data;
  } q_push_t;

endpackage

[rtl/p12du_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module p12du_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/p12du_outq.sv]
// Two-entry result queue between the table read and the result channel.
module p12du_outq (
  input  logic               clk,
  input  logic               rst,
  input  p12du_pkg::q_push_t push,
  output logic               room,
  output logic               result_valid,
  input  logic               result_stall,
  output p12du_pkg::result_t result
);

  import p12du_pkg::*;

  logic [1:0] cnt;
  logic [2:0] cnt_after;
  logic       pop;
  result_t    e0;
  result_t    e1;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (cnt != 2'd0);
  assign result       = e0;

  // A read issued now lands next cycle, so there must be a free slot then.
  assign cnt_after = 3'(cnt) + 3'(push.valid) - 3'(pop);
  assign room      = (cnt_after < 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_after[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && pop) begin
      if (cnt == 2'd1) begin
        e0 <= push.data;
      end else begin
        e0 <= e1;
        e1 <= push.data;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push.valid) begin
      if (cnt == 2'd0) begin
        e0 <= push.data;
      end else begin
        e1 <= push.data;
      end
    end
  end

endmodule

[rtl/packed12_depth_unpacker.sv]
// Top level of the packed 12-bit depth unpacker.
//
// Requests arrive on the item channel (item_valid, item_stall, item). A data
// request adds one byte to the current element; a table request writes one
// entry of the 4096-entry depth table. A byte with frame_begin set drops any
// partial element first. The byte that completes an element of ELEMENT_BYTES
// bytes releases CODES_PER_ELEMENT depth words on the result channel
// (result_valid, result_stall, result), the final one with last set.
// One request is taken per cycle while item_stall is low. The completing byte
// loads the code shift register; each code costs one read of the table RAM,
// whose single read port sets the pace of 1 word per cycle while there is room.
// A two-entry result queue keeps the read pipeline full across stalls.
// item_stall rises only while an element is still being read out: a table
// request waits, as does the byte that would complete the next element.
// When the receiver stalls, reads halt once the queue is full and the
// result held on the port stays unchanged.
// Reset empties the element and the result queue; table contents are kept
// and must be written before they are used.
module packed12_depth_unpacker #(
  parameter int ELEMENT_BYTES     = p12du_pkg::ELEMENT_BYTES_DEF,
  parameter int CODES_PER_ELEMENT = p12du_pkg::CODES_PER_ELEMENT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  p12du_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output p12du_pkg::result_t result
);

  import p12du_pkg::*;

  localparam int FILL_W    = $clog2(ELEMENT_BYTES);
  localparam int CNT_W     = $clog2(CODES_PER_ELEMENT);
  localparam int PAD_BYTES = ((CODES_PER_ELEMENT + 1) / 2) * 3;
  localparam int ADDR_W    = $clog2(TABLE_DEPTH);

  logic [BYTE_W-1:0] element_bytes [ELEMENT_BYTES];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_base;
  logic [BYTE_W-1:0] full_bytes [PAD_BYTES];
  logic [CODE_W-1:0] new_codes [CODES_PER_ELEMENT];
  logic [CODE_W-1:0] code_sr [CODES_PER_ELEMENT];
  logic [CNT_W-1:0]  code_cnt;
  logic              busy;
  logic              accept;
  logic              take_byte;
  logic              complete;
  logic              last_fill;
  logic              issue;
  logic              issue_last;
  logic              room;
  logic              rd_valid;
  logic              rd_last;
  logic [DEPTH_W-1:0] rd_depth;
  q_push_t           push;

  assign last_fill  = (fill == FILL_W'(ELEMENT_BYTES - 1));
  assign item_stall = busy && ((item.op == OP_TABLE) || (last_fill && !item.frame_begin));
  assign accept     = item_valid && !item_stall;
  assign take_byte  = accept && (item.op == OP_DATA);
  assign fill_base  = item.frame_begin ? '0 : fill;
  assign complete   = take_byte && (fill_base == FILL_W'(ELEMENT_BYTES - 1));

  // The completing byte is still on the port, so it is merged in here.
  // Bytes past the element read as zero.
  for (genvar i = 0; i < PAD_BYTES; i++) begin : g_full
    if (i < ELEMENT_BYTES - 1) begin : g_held
      assign full_bytes[i] = element_bytes[i];
    end else if (i == ELEMENT_BYTES - 1) begin : g_cur
      assign full_bytes[i] = item.data_byte;
    end else begin : g_pad
      assign full_bytes[i] = '0;
    end
  end

  // Every three bytes give two codes, high nibble first.
  for (genvar k = 0; k < CODES_PER_ELEMENT; k++) begin : g_code
    localparam int BASE = (k / 2) * 3;
    if (k % 2 == 0) begin : g_even
      assign new_codes[k] = {full_bytes[BASE], full_bytes[BASE+1][7:4]};
    end else begin : g_odd
      assign new_codes[k] = {full_bytes[BASE+1][3:0], full_bytes[BASE+2]};
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      element_bytes[fill_base] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take_byte) begin
      fill <= complete ? '0 : fill_base + FILL_W'(1);
    end
  end

  assign issue      = busy && room;
  assign issue_last = (code_cnt == CNT_W'(CODES_PER_ELEMENT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      code_cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (complete) begin
        busy     <= 1'b1;
        code_cnt <= '0;
      end else if (issue) begin
        code_cnt <= code_cnt + CNT_W'(1);
        if (issue_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= issue_last;
    end
    if (complete) begin
      code_sr <= new_codes;
    end else if (issue) begin
      for (int i = 0; i < CODES_PER_ELEMENT - 1; i++) begin
        code_sr[i] <= code_sr[i+1];
      end
    end
  end

  p12du_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (accept && (item.op == OP_TABLE)),
    .waddr (ADDR_W'(item.table_index)),
    .wdata (item.table_value),
    .raddr (ADDR_W'(code_sr[0])),
    .rdata (rd_depth)
  );

  assign push.valid      = rd_valid;
  assign push.data.depth = rd_depth;
  assign push.data.last  = rd_last;

  p12du_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[rtl/p12du_chk.sv]
// Port checker for the packed 12-bit depth unpacker, bound to the top level.
`include "packed12_depth_unpacker_macros.svh"

module p12du_chk (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input p12du_pkg::item_t   item,
  input logic               result_valid,
  input logic               result_stall,
  input p12du_pkg::result_t result
);

  import p12du_pkg::*;

  // Reset empties the result queue.
  `P12DU_ASSERT_ALWAYS(a_reset_empty, $past(rst), !result_valid, "result valid after reset")

  // A held result must not move while the receiver stalls.
  `P12DU_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // A frame start never completes an element, so it is never held back.
  `P12DU_ASSERT_IMPL(a_frame_go, item_valid && (item.op == OP_DATA) && item.frame_begin, !item_stall, "frame start stalled")

  // An element has at least two words, so two last words never follow each other.
  `P12DU_ASSERT_NEXT(a_last_gap, result_valid && !result_stall && result.last, !(result_valid && result.last), "two last words in a row")

endmodule

bind packed12_depth_unpacker p12du_chk u_chk (.*);

[tb/sv/packed12_depth_unpacker_tb.sv]
// Self-checking testbench of the packed 12-bit depth unpacker, with a cycle-free predictor.
`timescale 1ns / 1ps

module packed12_depth_unpacker_tb;
  import p12du_pkg::*;

  localparam int N_BYTES      = ELEMENT_BYTES_DEF;
  localparam int N_CODES      = CODES_PER_ELEMENT_DEF;
  localparam int GAP_MAX      = 18;
  localparam int STUCK_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_UNTIL = 110;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  packed12_depth_unpacker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Predictor state.
  logic [BYTE_W-1:0]  gathered [N_BYTES];
  int unsigned        gathered_count;
  logic [DEPTH_W-1:0] depth_lut [TABLE_DEPTH];
  result_t            depth_words_due [$];
  result_t            oldest_due;

  // Stimulus state.
  logic [CODE_W-1:0]  loaded_codes [$];
  bit                 lut_loaded [TABLE_DEPTH];
  logic [CODE_W-1:0]  element_codes [N_CODES];
  bit                 partial_pending;
  bit                 mix_tables;
  bit                 quiet;
  int unsigned        items_sent;
  int unsigned        mismatches;
  int unsigned        idle_cycles;
  int unsigned        stall_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [BYTE_W-1:0] gathered_byte(int unsigned idx);
    if (idx < N_BYTES) return gathered[idx];
    return '0;
  endfunction

  function automatic logic [CODE_W-1:0] code_of(int unsigned k);
    int unsigned       base;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    base = (k / 2) * 3;
    b0 = gathered_byte(base);
    b1 = gathered_byte(base + 1);
    b2 = gathered_byte(base + 2);
    if (k % 2 == 0) return {b0, b1[7:4]};
    return {b1[3:0], b2};
  endfunction

  function automatic void predict_request(item_t req);
    result_t word;
    if (req.op == OP_TABLE) begin
      depth_lut[req.table_index] = req.table_value;
      return;
    end
    if (req.frame_begin) gathered_count = 0;
    if (gathered_count < N_BYTES) gathered[gathered_count] = req.data_byte;
    gathered_count++;
    if (gathered_count < N_BYTES) return;
    gathered_count = 0;
    for (int k = 0; k < N_CODES; k++) begin
      word.depth = depth_lut[code_of(k)];
      word.last  = (k == N_CODES - 1);
      depth_words_due.push_back(word);
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: depth word mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Requests are predicted at the edge that accepts them, ahead of their results.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) predict_request(item);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (depth_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word depth=%h last=%b", result.depth, result.last));
      end else begin
        oldest_due = depth_words_due.pop_front();
        if (result.depth !== oldest_due.depth)
          report_mismatch($sformatf("depth %h, expected %h", result.depth, oldest_due.depth));
        if (result.last !== oldest_due.last)
          report_mismatch($sformatf("last %b, expected %b", result.last, oldest_due.last));
      end
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, GAP_MAX - 1);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("packed12_depth_unpacker_tb NOT OK");
      $finish;
    end
  end

  task automatic send_request(item_t req);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Table fields are filled at random on data requests, since the block must ignore them.
  function automatic item_t data_request(logic [BYTE_W-1:0] b, logic fb);
    item_t req;
    req.op          = OP_DATA;
    req.data_byte   = b;
    req.frame_begin = fb;
    req.table_index = CODE_W'($urandom_range(0, TABLE_DEPTH - 1));
    req.table_value = DEPTH_W'($urandom_range(0, 65535));
    return req;
  endfunction

  task automatic load_depth(logic [CODE_W-1:0] idx, logic [DEPTH_W-1:0] value);
    item_t req;
    req.op          = OP_TABLE;
    req.data_byte   = BYTE_W'($urandom_range(0, 255));
    req.frame_begin = 1'($urandom_range(0, 1));
    req.table_index = idx;
    req.table_value = value;
    send_request(req);
    if (!lut_loaded[idx]) begin
      lut_loaded[idx] = 1'b1;
      loaded_codes.push_back(idx);
    end
  endtask

  task automatic load_random_entry();
    logic [CODE_W-1:0] idx;
    if (loaded_codes.size() != 0 && $urandom_range(0, 3) == 0)
      idx = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
    else
      idx = CODE_W'($urandom_range(0, TABLE_DEPTH - 1));
    load_depth(idx, DEPTH_W'($urandom_range(0, 65535)));
  endtask

  // Codes are drawn only from loaded entries, so no element reads an unwritten one.
  function automatic void pick_random_codes();
    for (int k = 0; k < N_CODES; k++)
      element_codes[k] = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
  endfunction

  task automatic send_element(logic first_fb);
    logic [BYTE_W-1:0] packed_bytes [N_BYTES];
    for (int p = 0; p < N_CODES / 2; p++) begin
      packed_bytes[3*p]   = element_codes[2*p][11:4];
      packed_bytes[3*p+1] = {element_codes[2*p][3:0], element_codes[2*p+1][11:8]};
      packed_bytes[3*p+2] = element_codes[2*p+1][7:0];
    end
    for (int i = 0; i < N_BYTES; i++) begin
      // A table request in the middle of an element must leave the gathered bytes alone.
      if (mix_tables && $urandom_range(0, 15) == 0) load_random_entry();
      send_request(data_request(packed_bytes[i], (i == 0) ? first_fb : 1'b0));
    end
    partial_pending = 1'b0;
  endtask

  // A broken element: never long enough to complete, and dropped by the next frame begin.
  task automatic send_partial();
    int unsigned n;
    logic        fb;
    n = $urandom_range(1, N_BYTES - 1);
    for (int i = 0; i < n; i++) begin
      fb = 1'($urandom_range(0, 1));
      if (i == 0 && partial_pending) fb = 1'b1;
      send_request(data_request(BYTE_W'($urandom_range(0, 255)), fb));
    end
    partial_pending = 1'b1;
  endtask

  task automatic test_table_extremes();
    load_depth(12'h000, 16'hFFFF);
    load_depth(12'hFFF, 16'h0000);
    load_depth(12'hA5A, 16'h5A5A);
    load_depth(12'h5A5, DEPTH_W'($urandom_range(0, 65535)));
    load_depth(12'h000, 16'h8001);
  endtask

  task automatic test_frame_drop();
    send_request(data_request(8'hFF, 1'b0));
    send_request(data_request(8'h00, 1'b0));
    partial_pending = 1'b1;
    for (int k = 0; k < N_CODES; k++) begin
      case (k % 4)
        0: element_codes[k] = 12'h000;
        1: element_codes[k] = 12'hFFF;
        2: element_codes[k] = 12'hA5A;
        default: element_codes[k] = 12'h5A5;
      endcase
    end
    send_element(1'b1);
  endtask

  task automatic test_random_stream();
    int unsigned choice;
    mix_tables = 1'b1;
    while (items_sent < RANDOM_UNTIL) begin
      choice = $urandom_range(0, 9);
      if (choice < 2) begin
        load_random_entry();
      end else if (choice == 2) begin
        send_partial();
      end else begin
        pick_random_codes();
        send_element(partial_pending ? 1'b1 : 1'($urandom_range(0, 1)));
      end
    end
    mix_tables = 1'b0;
  endtask

  // Full rate on both sides; the table request straight after a completing byte
  // must wait for the readout, which still uses the old value.
  task automatic test_full_rate();
    logic [CODE_W-1:0] reused;
    quiet = 1'b1;
    pick_random_codes();
    reused = element_codes[N_CODES - 1];
    send_element(1'b1);
    load_depth(reused, DEPTH_W'($urandom_range(0, 65535)));
    pick_random_codes();
    element_codes[0] = reused;
    send_element(1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst             = 1'b1;
    item_valid      = 1'b0;
    item            = '0;
    result_stall    = 1'b0;
    stall_left      = 0;
    idle_cycles     = 0;
    gathered_count  = 0;
    items_sent      = 0;
    mismatches      = 0;
    partial_pending = 1'b0;
    mix_tables      = 1'b0;
    quiet           = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_table_extremes();
    test_frame_drop();
    test_random_stream();
    test_full_rate();

    item_valid <= 1'b0;
    while (depth_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("packed12_depth_unpacker_tb OK");
    end else begin
      $display("packed12_depth_unpacker_tb NOT OK");
    end
    $finish;
  end

endmodule
